// ===== rtl/mcs_pkg.sv =====
// ----------------------------------------------------------------------------
// mcs_pkg
// Types, widths and constants shared by the microcode sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package mcs_pkg;

  // field widths
  localparam int unsigned AddrW    = 13;
  localparam int unsigned WordW    = 24;
  localparam int unsigned AdcW     = 10;
  localparam int unsigned PeriodW  = 20;
  localparam int unsigned StepW    = 3;
  localparam int unsigned BitSelW  = 3;
  localparam int unsigned InstrW   = 8;
  localparam int unsigned OpW      = 2;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned ByteW    = 8;

  localparam int unsigned StoreDepth = 1 << AddrW;

  // the high control byte carries the halt flags
  localparam int unsigned HaltByteLsb = 16;
  // running half-period scale: difference shifted by this many bits
  localparam int unsigned ScaleShift  = 10;

  localparam logic [PeriodW-1:0] PausedPeriod = 20'd69;
  localparam logic [PeriodW-1:0] ResetPeriod  = 20'd1000000;

  // configuration reset values
  localparam logic [AdcW-1:0]    PauseThrRst   = 10'd50;
  localparam logic [AdcW-1:0]    MaxThrRst     = 10'd1000;
  localparam logic [AdcW-1:0]    MinPeriodRst  = 10'd400;
  localparam logic [BitSelW-1:0] StepRstBitRst = 3'd0;
  localparam logic [BitSelW-1:0] HaltBitRst    = 3'd0;

  typedef enum logic [OpW-1:0] {
    OP_LOAD = 2'd0,
    OP_ADC  = 2'd1,
    OP_STEP = 2'd2
  } opcode_e;

  typedef enum logic [ModeW-1:0] {
    MODE_PAUSE = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_MAX   = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAUSE_THR    = 3'd0,
    CFG_MAX_THR      = 3'd1,
    CFG_MIN_PERIOD   = 3'd2,
    CFG_STEP_RST_BIT = 3'd3,
    CFG_HALT_BIT     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [AdcW-1:0]    pause_thr;
    logic [AdcW-1:0]    max_thr;
    logic [AdcW-1:0]    min_period;
    logic [BitSelW-1:0] step_reset_bit;
    logic [BitSelW-1:0] halt_bit;
  } mcs_cfg_t;

  typedef struct packed {
    logic [StepW-1:0]   step;
    logic               halted;
    mode_e              mode;
    logic [PeriodW-1:0] period;
  } mcs_state_t;

  typedef struct packed {
    logic [WordW-1:0]   control_word;
    logic               stepped;
    logic [StepW-1:0]   used_step;
    logic [StepW-1:0]   next_step;
    logic               halted_now;
    logic [ModeW-1:0]   speed_mode;
    logic [PeriodW-1:0] half_period;
  } mcs_result_t;

  typedef struct packed {
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic [WordW-1:0] wr_data;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
  } mcs_store_req_t;

endpackage

`default_nettype wire

// ===== rtl/mcs_if.sv =====
// ----------------------------------------------------------------------------
// mcs_if
// Valid/ready channels of the microcode sequencer: items, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

// input item channel
interface mcs_req_if;
  logic                         valid;
  logic                         ready;
  logic [mcs_pkg::OpW-1:0]      opcode;
  logic [mcs_pkg::AddrW-1:0]    store_address;
  logic [mcs_pkg::WordW-1:0]    store_word;
  logic [mcs_pkg::AdcW-1:0]     adc_value;
  logic [mcs_pkg::InstrW-1:0]   instruction;
  logic                         carry_flag;
  logic                         zero_flag;

  modport source (output valid, opcode, store_address, store_word, adc_value,
                  instruction, carry_flag, zero_flag, input ready);
  modport sink   (input valid, opcode, store_address, store_word, adc_value,
                  instruction, carry_flag, zero_flag, output ready);
endinterface

// result channel
interface mcs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mcs_pkg::WordW-1:0]    control_word;
  logic                         stepped;
  logic [mcs_pkg::StepW-1:0]    used_step;
  logic [mcs_pkg::StepW-1:0]    next_step;
  logic                         halted_now;
  logic [mcs_pkg::ModeW-1:0]    speed_mode;
  logic [mcs_pkg::PeriodW-1:0]  half_period;

  modport source (output valid, control_word, stepped, used_step, next_step,
                  halted_now, speed_mode, half_period, input ready);
  modport sink   (input valid, control_word, stepped, used_step, next_step,
                  halted_now, speed_mode, half_period, output ready);
endinterface

// configuration write channel
interface mcs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mcs_pkg::CfgIdxW-1:0]   index;
  logic [mcs_pkg::CfgDataW-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/microcode_sequencer_with_clock_pacing_core.sv =====
// An accepted transaction passes the input and control store read registers,
// then the result register, before its result is offered.
// Throughput: load and ADC transactions are taken every cycle unless the result
// side stalls; none is taken while a step waits in the input stage, since the
// step counter for the next address settles only once the store word is decoded.
// Reset: step counter, halt latch, speed mode, half-period and configuration are
// set to their defaults at once; the control store is not initialised.
// ----------------------------------------------------------------------------
// microcode_sequencer_with_clock_pacing_core
// Microcode sequencer with a loadable control store and clock speed pacing.
// ----------------------------------------------------------------------------
`default_nettype none

module microcode_sequencer_with_clock_pacing_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  mcs_cfg_if.sink    cfg_i,
  mcs_req_if.sink    req_i,
  mcs_rsp_if.source  rsp_o
);
  import mcs_pkg::*;

  mcs_cfg_t       cfg_q;
  mcs_state_t     state_q, state_d;
  mcs_store_req_t store_req;
  mcs_result_t    result, rsp_q;
  logic [WordW-1:0] rdata;

  logic             s1_valid_q;
  logic [OpW-1:0]   s1_op_q;
  logic [AdcW-1:0]  s1_adc_q;
  logic             rsp_valid_q;

  logic out_free, s1_adv, s1_is_step, req_ready, req_fire;

  // handshake control
  always_comb begin
    out_free   = !rsp_valid_q || rsp_o.ready;
    s1_adv     = s1_valid_q && out_free;
    s1_is_step = s1_valid_q && (s1_op_q == OP_STEP);
    req_ready  = (!s1_valid_q || s1_adv) && !s1_is_step;
    req_fire   = req_i.valid && req_ready;
  end

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pause_thr      <= PauseThrRst;
      cfg_q.max_thr        <= MaxThrRst;
      cfg_q.min_period     <= MinPeriodRst;
      cfg_q.step_reset_bit <= StepRstBitRst;
      cfg_q.halt_bit       <= HaltBitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_PAUSE_THR:    cfg_q.pause_thr      <= cfg_i.data[AdcW-1:0];
        CFG_MAX_THR:      cfg_q.max_thr        <= cfg_i.data[AdcW-1:0];
        CFG_MIN_PERIOD:   cfg_q.min_period     <= cfg_i.data[AdcW-1:0];
        CFG_STEP_RST_BIT: cfg_q.step_reset_bit <= cfg_i.data[BitSelW-1:0];
        CFG_HALT_BIT:     cfg_q.halt_bit       <= cfg_i.data[BitSelW-1:0];
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end
  end

  // control store access at acceptance
  always_comb begin
    store_req.wr_en   = req_fire && (req_i.opcode == OP_LOAD);
    store_req.wr_addr = req_i.store_address;
    store_req.wr_data = req_i.store_word;
    store_req.rd_en   = req_fire && (req_i.opcode == OP_STEP);
    store_req.rd_addr = {req_i.zero_flag, req_i.carry_flag, state_q.step,
                         req_i.instruction};
  end

  mcs_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (rdata)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q  <= req_i.opcode;
      s1_adc_q <= req_i.adc_value;
    end
  end

  mcs_exec u_exec (
    .op_i     (s1_op_q),
    .adc_i    (s1_adc_q),
    .rdata_i  (rdata),
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // sequencer state, updated as each transaction retires
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.step   <= '0;
      state_q.halted <= 1'b0;
      state_q.mode   <= MODE_PAUSE;
      state_q.period <= ResetPeriod;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_q <= result;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.control_word = rsp_q.control_word;
  assign rsp_o.stepped      = rsp_q.stepped;
  assign rsp_o.used_step    = rsp_q.used_step;
  assign rsp_o.next_step    = rsp_q.next_step;
  assign rsp_o.halted_now   = rsp_q.halted_now;
  assign rsp_o.speed_mode   = rsp_q.speed_mode;
  assign rsp_o.half_period  = rsp_q.half_period;

endmodule

`default_nettype wire

// ===== rtl/mcs_store.sv =====
// ----------------------------------------------------------------------------
// mcs_store
// Control store: single write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_store (
  input  wire                     clk_i,
  input  wire mcs_pkg::mcs_store_req_t req_i,
  output logic [mcs_pkg::WordW-1:0] rdata_o
);
  import mcs_pkg::*;

  logic [WordW-1:0] store_q [StoreDepth];
  logic [WordW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      store_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= store_q[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/mcs_exec.sv =====
// ----------------------------------------------------------------------------
// mcs_exec
// Executes one transaction against the sequencer state: speed classification,
// step decode of the control word, halt latch.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_exec (
  input  wire [mcs_pkg::OpW-1:0]    op_i,
  input  wire [mcs_pkg::AdcW-1:0]   adc_i,
  input  wire [mcs_pkg::WordW-1:0]  rdata_i,
  input  wire mcs_pkg::mcs_cfg_t    cfg_i,
  input  wire mcs_pkg::mcs_state_t  state_i,
  output mcs_pkg::mcs_state_t       state_o,
  output mcs_pkg::mcs_result_t      result_o
);
  import mcs_pkg::*;

  logic               eligible;
  logic [AdcW-1:0]    speed_diff;
  logic [PeriodW-1:0] run_period;
  logic [ByteW-1:0]   ctrl_byte;
  logic [ByteW-1:0]   halt_byte;
  logic [WordW-1:0]   word;
  logic               stepped;

  // step allowed only with the clock going and not halted
  assign eligible   = ((state_i.mode == MODE_RUN) || (state_i.mode == MODE_MAX)) &&
                      !state_i.halted;
  assign speed_diff = cfg_i.max_thr - adc_i;
  assign run_period = {speed_diff, {ScaleShift{1'b0}}} + PeriodW'(cfg_i.min_period);
  assign ctrl_byte  = rdata_i[ByteW-1:0];
  assign halt_byte  = rdata_i[HaltByteLsb +: ByteW];

  // state update
  always_comb begin
    state_o = state_i;
    word    = '0;
    stepped = 1'b0;
    unique case (opcode_e'(op_i))
      OP_ADC: begin
        if (adc_i < cfg_i.pause_thr) begin
          state_o.mode   = MODE_PAUSE;
          state_o.period = PausedPeriod;
        end else if (adc_i > cfg_i.max_thr) begin
          state_o.mode   = MODE_MAX;
          state_o.period = PeriodW'(cfg_i.min_period);
        end else begin
          state_o.mode   = MODE_RUN;
          state_o.period = run_period;
        end
      end
      OP_STEP: begin
        if (eligible) begin
          word    = rdata_i;
          stepped = 1'b1;
          if (ctrl_byte[cfg_i.step_reset_bit]) begin
            state_o.step = '0;
          end else begin
            state_o.step = state_i.step + StepW'(1);
          end
          if (halt_byte[cfg_i.halt_bit]) begin
            state_o.halted = 1'b1;
          end
        end
      end
      default: begin
        // loads touch only the store, unused code is ignored
      end
    endcase
  end

  // result fields
  always_comb begin
    result_o.control_word = word;
    result_o.stepped      = stepped;
    result_o.used_step    = state_i.step;
    result_o.next_step    = state_o.step;
    result_o.halted_now   = state_o.halted;
    result_o.speed_mode   = state_o.mode;
    result_o.half_period  = state_o.period;
  end

endmodule

`default_nettype wire

// ===== rtl/mcs_checker.sv =====
// ----------------------------------------------------------------------------
// mcs_checker
// Port-level checks on the result channel of the microcode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mcs_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          rsp_valid_i,
  input wire                          rsp_ready_i,
  input wire [mcs_pkg::WordW-1:0]     control_word_i,
  input wire                          stepped_i,
  input wire [mcs_pkg::StepW-1:0]     used_step_i,
  input wire [mcs_pkg::StepW-1:0]     next_step_i,
  input wire [mcs_pkg::ModeW-1:0]     speed_mode_i,
  input wire [mcs_pkg::PeriodW-1:0]   half_period_i
);
  import mcs_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn while stalled");

  // no step issued means no control word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !stepped_i |-> control_word_i == '0)
    else $error("control word without a step");

  // step counter moves only on an issued step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !stepped_i |-> next_step_i == used_step_i)
    else $error("step counter moved without a step");

  // a step is issued only with the clock going
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && stepped_i |-> speed_mode_i != MODE_PAUSE)
    else $error("step issued while paused");

  // at maximum speed the half-period is the short minimum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && speed_mode_i == MODE_MAX |-> half_period_i[PeriodW-1:AdcW] == '0)
    else $error("half-period too long at maximum speed");

endmodule

bind microcode_sequencer_with_clock_pacing_core mcs_checker u_mcs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .control_word_i (rsp_o.control_word),
  .stepped_i      (rsp_o.stepped),
  .used_step_i    (rsp_o.used_step),
  .next_step_i    (rsp_o.next_step),
  .speed_mode_i   (rsp_o.speed_mode),
  .half_period_i  (rsp_o.half_period)
);

`default_nettype wire

// ===== dv/mcs_sequencer_monitor.sv =====
// ----------------------------------------------------------------------------
// mcs_sequencer_monitor
// Passive monitor for the microcode sequencer. It tracks configuration writes,
// predicts the result of every accepted input transaction from its own copy of
// the control store and sequencer state, and compares each result
// transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mcs_sequencer_monitor
  import mcs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mcs_req_if   req_i,
  mcs_rsp_if   rsp_i,
  mcs_cfg_if   cfg_i,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the sequencer
  logic [WordW-1:0]   ctrl_store [StoreDepth];
  logic [StepW-1:0]   step_q;
  logic               halt_q;
  mode_e              mode_q;
  logic [PeriodW-1:0] period_q;
  mcs_cfg_t           cfg_q;

  mcs_result_t result_q [$];

  // work out the result of one item and advance the shadow state
  function automatic mcs_result_t sequencer_result(
    input logic [OpW-1:0]    op,
    input logic [AddrW-1:0]  addr,
    input logic [WordW-1:0]  word,
    input logic [AdcW-1:0]   adc,
    input logic [InstrW-1:0] instr,
    input logic              cflag,
    input logic              zflag
  );
    mcs_result_t      r;
    logic [AddrW-1:0] rd_addr;
    logic [WordW-1:0] rd_word;
    r = '0;
    r.used_step = step_q;
    case (op)
      OP_LOAD: ctrl_store[addr] = word;
      OP_ADC: begin
        if (adc < cfg_q.pause_thr) begin
          mode_q   = MODE_PAUSE;
          period_q = PausedPeriod;
        end else if (adc > cfg_q.max_thr) begin
          mode_q   = MODE_MAX;
          period_q = PeriodW'(cfg_q.min_period);
        end else begin
          mode_q   = MODE_RUN;
          period_q = PeriodW'(cfg_q.min_period)
                   + (PeriodW'(cfg_q.max_thr - adc) << ScaleShift);
        end
      end
      OP_STEP: begin
        if ((mode_q == MODE_RUN || mode_q == MODE_MAX) && !halt_q) begin
          rd_addr = {zflag, cflag, step_q, instr};
          rd_word = ctrl_store[rd_addr];
          r.control_word = rd_word;
          r.stepped      = 1'b1;
          if (rd_word[cfg_q.step_reset_bit]) step_q = '0;
          else step_q = step_q + 1'b1;
          if (rd_word[HaltByteLsb + cfg_q.halt_bit]) halt_q = 1'b1;
        end
      end
      default: ;
    endcase
    r.next_step   = step_q;
    r.halted_now  = halt_q;
    r.speed_mode  = mode_q;
    r.half_period = period_q;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt_o++;
    end
  endfunction

  // observe all three channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    mcs_result_t want;
    if (!rst_ni) begin
      step_q     = '0;
      halt_q     = 1'b0;
      mode_q     = MODE_PAUSE;
      period_q   = ResetPeriod;
      cfg_q      = '{PauseThrRst, MaxThrRst, MinPeriodRst, StepRstBitRst, HaltBitRst};
      result_q.delete();
      pending_o  = 0;
    end else begin
      // result transaction against the oldest prediction
      if (rsp_i.valid && rsp_i.ready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_cnt_o++;
        end else begin
          want = result_q.pop_front();
          check_field("control_word", want.control_word, rsp_i.control_word);
          check_field("stepped", want.stepped, rsp_i.stepped);
          check_field("used_step", want.used_step, rsp_i.used_step);
          check_field("next_step", want.next_step, rsp_i.next_step);
          check_field("halted_now", want.halted_now, rsp_i.halted_now);
          check_field("speed_mode", want.speed_mode, rsp_i.speed_mode);
          check_field("half_period", want.half_period, rsp_i.half_period);
        end
      end
      // input transaction
      if (req_i.valid && req_i.ready) begin
        result_q.push_back(sequencer_result(req_i.opcode, req_i.store_address,
                                            req_i.store_word, req_i.adc_value,
                                            req_i.instruction, req_i.carry_flag,
                                            req_i.zero_flag));
      end
      // register write
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_PAUSE_THR:    cfg_q.pause_thr      = cfg_i.data;
          CFG_MAX_THR:      cfg_q.max_thr        = cfg_i.data;
          CFG_MIN_PERIOD:   cfg_q.min_period     = cfg_i.data;
          CFG_STEP_RST_BIT: cfg_q.step_reset_bit = cfg_i.data[BitSelW-1:0];
          CFG_HALT_BIT:     cfg_q.halt_bit       = cfg_i.data[BitSelW-1:0];
          default: ;
        endcase
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the microcode sequencer testbench. Drives a short directed sequence,
// then several configuration phases of random load, ADC and step traffic with
// random idling on both sides, and reports the verdict of the monitor.
// ----------------------------------------------------------------------------
module tb;
  import mcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int             QuietLimit = 2000;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [AddrW-1:0]  addr;
    logic [WordW-1:0]  word;
    logic [AdcW-1:0]   adc;
    logic [InstrW-1:0] instr;
    logic              cflag;
    logic              zflag;
  } stim_t;

  logic clk_i;
  logic rst_ni;
  int   fail_cnt;
  int   pending;
  int   quiet_cycles;
  bit   req_burst;
  bit   rsp_burst;

  // register values the stimulus steers by
  logic [AdcW-1:0]    cur_pause    = PauseThrRst;
  logic [AdcW-1:0]    cur_max      = MaxThrRst;
  logic [BitSelW-1:0] cur_rst_bit  = StepRstBitRst;
  logic [BitSelW-1:0] cur_halt_bit = HaltBitRst;

  mcs_req_if req_if ();
  mcs_rsp_if rsp_if ();
  mcs_cfg_if cfg_if ();

  microcode_sequencer_with_clock_pacing_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mcs_sequencer_monitor mon (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_i      (rsp_if),
    .cfg_i      (cfg_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic stim_t rand_item();
    stim_t it;
    it.op    = OpW'($urandom_range(0, 3));
    it.addr  = AddrW'($urandom);
    it.word  = WordW'($urandom);
    it.adc   = AdcW'($urandom);
    it.instr = InstrW'($urandom);
    it.cflag = 1'($urandom);
    it.zflag = 1'($urandom);
    return it;
  endfunction

  function automatic stim_t load_item(input logic [AddrW-1:0] a, input logic [WordW-1:0] w);
    stim_t it;
    it      = rand_item();
    it.op   = OP_LOAD;
    it.addr = a;
    it.word = w;
    return it;
  endfunction

  function automatic stim_t adc_item(input logic [AdcW-1:0] v);
    stim_t it;
    it     = rand_item();
    it.op  = OP_ADC;
    it.adc = v;
    return it;
  endfunction

  function automatic stim_t step_item(input logic [InstrW-1:0] i, input logic c,
                                      input logic z);
    stim_t it;
    it       = rand_item();
    it.op    = OP_STEP;
    it.instr = i;
    it.cflag = c;
    it.zflag = z;
    return it;
  endfunction

  // control word that rarely clears the step counter and halts only when allowed
  function automatic logic [WordW-1:0] make_word(input bit halting);
    logic [WordW-1:0] w;
    w = WordW'($urandom);
    if ($urandom_range(0, 7) != 0) w[cur_rst_bit] = 1'b0;
    if (!halting || $urandom_range(0, 15) != 0) w[HaltByteLsb + cur_halt_bit] = 1'b0;
    return w;
  endfunction

  // one input transaction after a random gap
  task automatic send_item(input stim_t it);
    int gap;
    gap = req_burst ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk_i);
      req_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_if.valid         <= 1'b1;
    req_if.opcode        <= it.op;
    req_if.store_address <= it.addr;
    req_if.store_word    <= it.word;
    req_if.adc_value     <= it.adc;
    req_if.instruction   <= it.instr;
    req_if.carry_flag    <= it.cflag;
    req_if.zero_flag     <= it.zflag;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // hold off the sender until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_PAUSE_THR:    cur_pause    = val;
      CFG_MAX_THR:      cur_max      = val;
      CFG_STEP_RST_BIT: cur_rst_bit  = val[BitSelW-1:0];
      CFG_HALT_BIT:     cur_halt_bit = val[BitSelW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input int pause_thr, input int max_thr, input int min_period,
                           input int rst_bit, input int halt_bit);
    wait_drained();
    write_reg(CFG_PAUSE_THR, CfgDataW'(pause_thr));
    write_reg(CFG_MAX_THR, CfgDataW'(max_thr));
    write_reg(CFG_MIN_PERIOD, CfgDataW'(min_period));
    write_reg(CFG_STEP_RST_BIT, CfgDataW'(rst_bit));
    write_reg(CFG_HALT_BIT, CfgDataW'(halt_bit));
  endtask

  // fill every step and flag combination of a few instructions, then mixed traffic
  task automatic run_phase(input bit halting, input int n_items);
    logic [InstrW-1:0] pool [4];
    stim_t             it;
    int                r;
    logic [AdcW-1:0]   v;
    pool[0] = 8'h00;
    pool[1] = 8'hFF;
    pool[2] = InstrW'($urandom);
    pool[3] = InstrW'($urandom);
    foreach (pool[p]) begin
      for (int s = 0; s < 32; s++) begin
        send_item(load_item({s[4:0], pool[p]}, make_word(halting)));
      end
    end
    for (int k = 0; k < n_items; k++) begin
      if (k % 32 == 0) req_burst = ($urandom_range(0, 3) == 0);
      if (k == n_items / 2) wait_drained();
      r = $urandom_range(0, 19);
      if (r < 3) begin
        // speed samples biased to keep the clock going, thresholds included
        case ($urandom_range(0, 7))
          0: v = AdcW'($urandom);
          1: v = cur_pause - 1'b1;
          2: v = cur_pause;
          3: v = cur_max;
          4: v = cur_max + 1'b1;
          5: v = '1;
          default: v = (cur_pause <= cur_max) ? AdcW'($urandom_range(cur_pause, cur_max))
                                              : '1;
        endcase
        it = adc_item(v);
      end else if (r < 14) begin
        it = step_item(pool[$urandom_range(0, 3)], 1'($urandom), 1'($urandom));
      end else if (r < 17) begin
        it = load_item(AddrW'($urandom), make_word(halting));
      end else if (r < 19) begin
        it = load_item({5'($urandom), pool[$urandom_range(0, 3)]}, make_word(halting));
      end else begin
        it    = rand_item();
        it.op = OpUnused;
      end
      send_item(it);
    end
  endtask

  // result side: random stall before each result
  initial begin : rsp_sink
    int stall;
    int n;
    rsp_if.ready = 1'b0;
    n = 0;
    @(posedge rst_ni);
    forever begin
      if (n % 40 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      n++;
      stall = rsp_burst ? 0 : $urandom_range(0, 5);
      repeat (stall) begin
        @(negedge clk_i);
        rsp_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  // main stimulus
  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.opcode        = '0;
    req_if.store_address = '0;
    req_if.store_word    = '0;
    req_if.adc_value     = '0;
    req_if.instruction   = '0;
    req_if.carry_flag    = 1'b0;
    req_if.zero_flag     = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    req_burst            = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset configuration
    // step and unused opcode while paused
    send_item(step_item(8'hFF, 1'b1, 1'b1));
    send_item('{op: OpUnused, addr: '1, word: '1, adc: '1, instr: '1, cflag: 1'b1,
                zflag: 1'b1});
    // samples around both thresholds
    send_item(adc_item(10'd0));
    send_item(adc_item(10'd49));
    send_item(adc_item(10'd50));
    send_item(adc_item(10'd1000));
    send_item(adc_item(10'd1001));
    send_item(adc_item(10'd1023));
    // store words for the directed steps, extremes included
    send_item(load_item(13'h0000, 24'hFEFFFE));
    send_item(load_item(13'h19FF, 24'h000001));
    send_item(load_item(13'h0800, 24'h000000));
    send_item(load_item(13'h1ABC, 24'hFFFFFF));
    // advance, step reset, zero word
    send_item(step_item(8'h00, 1'b0, 1'b0));
    send_item(step_item(8'hFF, 1'b1, 1'b1));
    send_item(step_item(8'h00, 1'b1, 1'b0));
    // step ignored while paused, then resume
    send_item(adc_item(10'd10));
    send_item(step_item(8'h00, 1'b0, 1'b0));
    send_item(adc_item(10'd700));
    send_item(load_item(13'h0100, 24'hFE00FE));
    send_item(step_item(8'h00, 1'b0, 1'b0));

    // random phases over several register settings
    apply_cfg(0, 1023, 1023, 7, 7);
    run_phase(1'b0, 140);
    apply_cfg(1023, 0, 0, 0, 0);
    run_phase(1'b0, 140);
    apply_cfg($urandom_range(0, 300), $urandom_range(600, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 7), $urandom_range(0, 7));
    run_phase(1'b0, 140);
    begin : equal_thresholds
      int thr;
      thr = $urandom_range(100, 900);
      apply_cfg(thr, thr, $urandom_range(0, 1023), $urandom_range(0, 7),
                $urandom_range(0, 7));
    end
    run_phase(1'b0, 140);
    apply_cfg($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 7), $urandom_range(0, 7));
    run_phase(1'b0, 140);
    // last phase lets words halt the sequencer
    apply_cfg($urandom_range(0, 200), $urandom_range(700, 1023), $urandom_range(0, 1023),
              $urandom_range(0, 7), $urandom_range(0, 7));
    run_phase(1'b1, 140);

    // drain and let any stray result show
    wait_drained();
    repeat (8) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== microcode_sequencer_with_clock_pacing_core.f =====
rtl/mcs_pkg.sv
rtl/mcs_if.sv
rtl/mcs_store.sv
rtl/mcs_exec.sv
rtl/microcode_sequencer_with_clock_pacing_core.sv
rtl/mcs_checker.sv
dv/mcs_sequencer_monitor.sv
dv/tb.sv
